// File: sv/mtep_pkg.sv
package mtep_pkg;

  // longest length code, in bytes, for delta times and meta lengths
  localparam int MAX_LEN_BYTES = 4;
  localparam int LB_W = $clog2(MAX_LEN_BYTES + 1);
  localparam int LEN_W = 28;
  localparam int TIME_W = 32;

  // status byte codes
  localparam logic [7:0] ST_META = 8'hFF;
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON = 4'h9;
  localparam logic [3:0] HI_CTRL = 4'hB;
  localparam logic [3:0] HI_PROG = 4'hC;
  localparam logic [3:0] HI_BEND = 4'hE;

  typedef enum logic [2:0] {
    PH_DELTA = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1 = 3'd2,
    PH_DATA2 = 3'd3,
    PH_MTYPE = 3'd4,
    PH_MLEN = 3'd5,
    PH_MDATA = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAN = 2'd0,
    KIND_META_HDR = 2'd1,
    KIND_META_DATA = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EV_OFF = 3'd0,
    EV_ON = 3'd1,
    EV_CTRL = 3'd2,
    EV_PROG = 3'd3,
    EV_BEND = 3'd4,
    EV_META = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_STATUS = 2'd1,
    ERR_OVERLONG = 2'd2
  } err_t;

  // one accepted input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic restart;
  } in_word_t;

  // one result word
  typedef struct packed {
    kind_t kind;
    logic [TIME_W-1:0] abs_time;
    ev_t event_type;
    logic [3:0] channel;
    logic [7:0] param_one;
    logic [7:0] param_two;
    logic [LEN_W-1:0] meta_len;
    logic [7:0] meta_byte;
    logic event_done;
    err_t error_code;
  } res_t;

  // core to output stage
  typedef struct packed {
    logic adv;
    logic vld;
  } res_ctl_t;

endpackage

// File: sv/mtep_in_reg.sv
module mtep_in_reg (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  mtep_pkg::in_word_t in_word,
  input  logic adv,
  output logic word_vld,
  output mtep_pkg::in_word_t word
);

  logic vld_r;
  mtep_pkg::in_word_t word_r;

  // slot frees when the core takes the held word
  assign in_tready = !vld_r || adv;
  assign word_vld = vld_r;
  assign word = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      word_r <= in_word;
    end
  end

endmodule

// File: sv/mtep_core.sv
module mtep_core (
  input  logic clk,
  input  logic rst_n,
  input  logic word_vld,
  input  mtep_pkg::in_word_t word,
  input  logic out_free,
  output mtep_pkg::res_ctl_t ctl,
  output mtep_pkg::res_t res
);

  localparam int LW = mtep_pkg::LEN_W;
  localparam int TW = mtep_pkg::TIME_W;
  localparam int LBW = mtep_pkg::LB_W;

  mtep_pkg::phase_t phase_r, phase_nxt, phase_c;
  logic [TW-1:0] time_r, time_nxt, time_c;
  logic [LW-1:0] acc_r, acc_nxt, acc_c;
  logic [LBW-1:0] lb_r, lb_nxt, lb_c;
  mtep_pkg::ev_t type_r, type_nxt, type_c;
  logic [3:0] ch_r, ch_nxt, ch_c;
  logic [7:0] first_r, first_nxt, first_c;
  logic [LW-1:0] left_r, left_nxt, left_c;
  logic halt_r, halt_nxt, halt_c;

  logic [7:0] b;
  logic [LBW-1:0] seen;
  logic [LW-1:0] acc_sh;
  logic [LW-1:0] left_m;
  logic overlong;
  logic adv;
  logic vld;

  assign b = word.data_byte;
  assign adv = word_vld && out_free;
  assign ctl = '{adv: adv, vld: vld};

  always_comb begin
    // restart clears everything before this byte is handled
    if (word.restart) begin
      phase_c = mtep_pkg::PH_DELTA;
      time_c = '0;
      acc_c = '0;
      lb_c = '0;
      type_c = mtep_pkg::EV_OFF;
      ch_c = '0;
      first_c = '0;
      left_c = '0;
      halt_c = 1'b0;
    end else begin
      phase_c = phase_r;
      time_c = time_r;
      acc_c = acc_r;
      lb_c = lb_r;
      type_c = type_r;
      ch_c = ch_r;
      first_c = first_r;
      left_c = left_r;
      halt_c = halt_r;
    end

    // length code helpers
    seen = lb_c + LBW'(1);
    acc_sh = {acc_c[LW-8:0], b[6:0]};
    overlong = b[7] && (32'(seen) >= mtep_pkg::MAX_LEN_BYTES);
    left_m = left_c - LW'(1);

    phase_nxt = phase_c;
    time_nxt = time_c;
    acc_nxt = acc_c;
    lb_nxt = lb_c;
    type_nxt = type_c;
    ch_nxt = ch_c;
    first_nxt = first_c;
    left_nxt = left_c;
    halt_nxt = halt_c;

    vld = 1'b0;
    res = '0;
    res.abs_time = time_c;

    if (!halt_c) begin
      unique case (phase_c)
        mtep_pkg::PH_DELTA: begin
          acc_nxt = acc_sh;
          if (overlong) begin
            halt_nxt = 1'b1;
            vld = 1'b1;
            res.kind = mtep_pkg::KIND_ERROR;
            res.param_one = b;
            res.error_code = mtep_pkg::ERR_OVERLONG;
          end else if (b[7]) begin
            lb_nxt = seen;
          end else begin
            lb_nxt = '0;
            time_nxt = time_c + TW'(acc_sh);
            acc_nxt = '0;
            phase_nxt = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          ch_nxt = b[3:0];
          phase_nxt = mtep_pkg::PH_DATA1;
          if (b == mtep_pkg::ST_META) begin
            type_nxt = mtep_pkg::EV_META;
            phase_nxt = mtep_pkg::PH_MTYPE;
          end else begin
            unique case (b[7:4])
              mtep_pkg::HI_NOTE_OFF: type_nxt = mtep_pkg::EV_OFF;
              mtep_pkg::HI_NOTE_ON: type_nxt = mtep_pkg::EV_ON;
              mtep_pkg::HI_CTRL: type_nxt = mtep_pkg::EV_CTRL;
              mtep_pkg::HI_PROG: type_nxt = mtep_pkg::EV_PROG;
              mtep_pkg::HI_BEND: type_nxt = mtep_pkg::EV_BEND;
              default: begin
                // unsupported status: report and halt
                halt_nxt = 1'b1;
                phase_nxt = phase_c;
                vld = 1'b1;
                res.kind = mtep_pkg::KIND_ERROR;
                res.channel = b[3:0];
                res.param_one = b;
                res.error_code = mtep_pkg::ERR_STATUS;
              end
            endcase
          end
        end
        mtep_pkg::PH_DATA1: begin
          if (type_c == mtep_pkg::EV_PROG) begin
            phase_nxt = mtep_pkg::PH_DELTA;
            vld = 1'b1;
            res.kind = mtep_pkg::KIND_CHAN;
            res.event_type = type_c;
            res.channel = ch_c;
            res.param_one = b;
            res.event_done = 1'b1;
          end else begin
            first_nxt = b;
            phase_nxt = mtep_pkg::PH_DATA2;
          end
        end
        mtep_pkg::PH_DATA2: begin
          phase_nxt = mtep_pkg::PH_DELTA;
          vld = 1'b1;
          res.kind = mtep_pkg::KIND_CHAN;
          res.event_type = type_c;
          res.channel = ch_c;
          res.param_one = first_c;
          res.param_two = b;
          res.event_done = 1'b1;
        end
        mtep_pkg::PH_MTYPE: begin
          first_nxt = b;
          acc_nxt = '0;
          lb_nxt = '0;
          phase_nxt = mtep_pkg::PH_MLEN;
        end
        mtep_pkg::PH_MLEN: begin
          acc_nxt = acc_sh;
          if (overlong) begin
            halt_nxt = 1'b1;
            vld = 1'b1;
            res.kind = mtep_pkg::KIND_ERROR;
            res.param_one = b;
            res.error_code = mtep_pkg::ERR_OVERLONG;
          end else if (b[7]) begin
            lb_nxt = seen;
          end else begin
            // length complete: header word
            lb_nxt = '0;
            left_nxt = acc_sh;
            vld = 1'b1;
            res.kind = mtep_pkg::KIND_META_HDR;
            res.event_type = mtep_pkg::EV_META;
            res.channel = ch_c;
            res.param_one = first_c;
            if (acc_sh == '0) begin
              phase_nxt = mtep_pkg::PH_DELTA;
              acc_nxt = '0;
              res.event_done = 1'b1;
            end else begin
              phase_nxt = mtep_pkg::PH_MDATA;
              res.meta_len = acc_sh;
            end
          end
        end
        mtep_pkg::PH_MDATA: begin
          left_nxt = left_m;
          vld = 1'b1;
          res.kind = mtep_pkg::KIND_META_DATA;
          res.event_type = mtep_pkg::EV_META;
          res.channel = ch_c;
          res.param_one = first_c;
          res.meta_len = acc_c;
          res.meta_byte = b;
          if (left_m == '0) begin
            res.event_done = 1'b1;
            phase_nxt = mtep_pkg::PH_DELTA;
            acc_nxt = '0;
          end
        end
        default: phase_nxt = mtep_pkg::PH_DELTA;
      endcase
    end
  end

  // parser state, updated as each word passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mtep_pkg::PH_DELTA;
      time_r <= '0;
      acc_r <= '0;
      lb_r <= '0;
      type_r <= mtep_pkg::EV_OFF;
      ch_r <= '0;
      first_r <= '0;
      left_r <= '0;
      halt_r <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      time_r <= time_nxt;
      acc_r <= acc_nxt;
      lb_r <= lb_nxt;
      type_r <= type_nxt;
      ch_r <= ch_nxt;
      first_r <= first_nxt;
      left_r <= left_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// File: sv/mtep_out_reg.sv
module mtep_out_reg (
  input  logic clk,
  input  logic rst_n,
  input  mtep_pkg::res_ctl_t ctl,
  input  mtep_pkg::res_t res,
  input  logic out_tready,
  output logic out_free,
  output logic out_tvalid,
  output mtep_pkg::res_t out_res
);

  logic vld_r;
  mtep_pkg::res_t res_r;

  assign out_free = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_free) begin
      vld_r <= ctl.adv && ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && ctl.adv && ctl.vld) begin
      res_r <= res;
    end
  end

endmodule

// File: sv/midi_track_event_parser.sv
// Track event parser for a Standard MIDI File track body.
// Input stream: one track byte per word. in_tdata is the raw byte; in_tuser
// is the restart flag, which clears time, parse state and halt before the
// byte is handled.
// Output stream: at most one result word per input byte: channel events,
// meta headers, meta data bytes (one per word) and error reports. out_tuser
// carries the result kind, out_tlast marks the word that completes an event.
// The input register captures each accepted byte; it passes once through the
// parser and its result goes into the output register. Throughput: one byte
// per cycle while the receiver takes results, set by the single state update
// per byte in the parser stage.
// Reset (rst_n low, synchronous): both registers empty, tick count zero,
// parser waiting for a delta time.
// When the receiver stalls, the held result stays in the output register
// and the parser stops; one more byte can wait in the input register, then
// in_tready drops until the receiver takes the held word.
// An error halts the parser: further bytes are accepted and dropped until
// one arrives with restart set.
module midi_track_event_parser (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [0:0] in_tuser,   // [0] restart
  output logic out_tvalid,
  input  logic out_tready,
  // [31:0] abs_time, [34:32] event_type, [38:35] channel, [46:39] param_one,
  // [54:47] param_two, [82:55] meta_len, [90:83] meta_byte,
  // [92:91] error_code, [95:93] zero
  output logic [95:0] out_tdata,
  output logic out_tlast,        // event_done
  output logic [1:0] out_tuser   // [1:0] kind
);

  mtep_pkg::in_word_t in_word, word;
  logic word_vld;
  logic out_free;
  mtep_pkg::res_ctl_t ctl;
  mtep_pkg::res_t res, out_res;

  assign in_word = '{data_byte: in_tdata, restart: in_tuser[0]};

  mtep_in_reg u_in (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_word(in_word),
    .adv(ctl.adv),
    .word_vld(word_vld),
    .word(word)
  );

  mtep_core u_core (
    .clk(clk),
    .rst_n(rst_n),
    .word_vld(word_vld),
    .word(word),
    .out_free(out_free),
    .ctl(ctl),
    .res(res)
  );

  mtep_out_reg u_out (
    .clk(clk),
    .rst_n(rst_n),
    .ctl(ctl),
    .res(res),
    .out_tready(out_tready),
    .out_free(out_free),
    .out_tvalid(out_tvalid),
    .out_res(out_res)
  );

  // pack result word
  assign out_tdata = {3'b000, out_res.error_code, out_res.meta_byte, out_res.meta_len,
                      out_res.param_two, out_res.param_one, out_res.channel,
                      out_res.event_type, out_res.abs_time};
  assign out_tlast = out_res.event_done;
  assign out_tuser = out_res.kind;

endmodule
